### src/csfw_pkg.sv
// shared constants, codes and types of the counting semaphore with waiter queue
package csfw_pkg;

  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 8;

  localparam int REQ_TYPE_W  = 2;
  localparam int THREAD_ID_W = 8;
  localparam int STATUS_W    = 4;
  localparam int REL_ID_W    = 8;
  localparam int COUNT_W     = 18;
  localparam int CFG_W       = 16;

  localparam logic [REQ_TYPE_W-1:0] REQ_WAIT   = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_SIGNAL = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLOSE  = 2'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_GRANTED      = 4'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_NO_WAITER    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_REL_SIGNAL   = 4'd3;
  localparam logic [STATUS_W-1:0] ST_REL_CLOSE    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_CLOSED_EMPTY = 4'd5;
  localparam logic [STATUS_W-1:0] ST_CLOSED_ERR   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_SATURATED    = 4'd8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one;
  } q_flags_t;

endpackage

### src/csfw_if.sv
// request and response channel interfaces
interface csfw_req_if;
  logic                             valid;
  logic                             ready;
  logic [csfw_pkg::REQ_TYPE_W-1:0]  req_type;
  logic [csfw_pkg::THREAD_ID_W-1:0] thread_id;

  modport source (output valid, output req_type, output thread_id, input ready);
  modport sink (input valid, input req_type, input thread_id, output ready);
endinterface

interface csfw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [csfw_pkg::STATUS_W-1:0] status;
  logic [csfw_pkg::REL_ID_W-1:0] released_thread;
  logic                          last;

  modport source (output valid, output status, output released_thread, output last,
                  input ready);
  modport sink (input valid, input status, input released_thread, input last,
                output ready);
endinterface

### src/csfw_queue.sv
// circular waiter queue in a synchronous memory, read port tracks the head
module csfw_queue #(
  parameter int DEPTH   = csfw_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS = csfw_pkg::THREAD_ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csfw_pkg::q_ctrl_t  ctrl,
  input  logic [ID_BITS-1:0] push_id,
  output csfw_pkg::q_flags_t flags,
  output logic [ID_BITS-1:0] rd_id
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [ID_BITS-1:0] mem [DEPTH];
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [ID_BITS-1:0] rd_id_r;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    if (ctrl.pop) begin
      head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    end
    if (ctrl.push) begin
      tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
    end
    if (ctrl.push && !ctrl.pop) begin
      occ_nxt = occ_r + 1'b1;
    end else if (ctrl.pop && !ctrl.push) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
    end
  end

  // read address follows the next head so the head entry is always ready
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail_r] <= push_id;
    end
    rd_id_r <= mem[head_nxt];
  end

  assign rd_id       = rd_id_r;
  assign flags.empty = (occ_r == '0);
  assign flags.full  = (occ_r == OCC_W'(DEPTH));
  assign flags.one   = (occ_r == OCC_W'(1));

endmodule

### src/counting_semaphore_fifo_waiters.sv
// Counting semaphore with a FIFO queue of waiting thread ids. Each request is first accepted
// and then, in an update step, changes the count and the waiter queue, whose entries sit in a
// synchronous memory read at the queue head. A close releases queued waiters one per cycle while
// the result side keeps taking them. Results leave through an output register;
// a request that finds that register still full waits in its update cycle until it drains.
// A write to cfg_wdata loads the count only; the queue and the closed state are kept.
module counting_semaphore_fifo_waiters #(
  parameter int QUEUE_DEPTH    = csfw_pkg::QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = csfw_pkg::THREAD_ID_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  csfw_req_if.sink                   in_req,
  csfw_rsp_if.source                 out_rsp,
  input  logic                       cfg_we,
  input  logic [csfw_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int EXT_W = THREAD_ID_BITS + csfw_pkg::THREAD_ID_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                          state_r, state_nxt;
  logic [csfw_pkg::REQ_TYPE_W-1:0]     req_type_r;
  logic [THREAD_ID_BITS-1:0]           tid_r;
  logic signed [csfw_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                                closed_r, closed_nxt;

  logic                                out_valid_r;
  logic [csfw_pkg::STATUS_W-1:0]       out_status_r;
  logic [csfw_pkg::REL_ID_W-1:0]       out_rel_r;
  logic                                out_last_r;

  logic                                out_free;
  logic                                out_load;
  logic [csfw_pkg::STATUS_W-1:0]       ld_status;
  logic [csfw_pkg::REL_ID_W-1:0]       ld_rel;
  logic                                ld_last;

  logic [EXT_W-1:0]                    tid_ext;
  logic [EXT_W-1:0]                    rel_ext;
  csfw_pkg::q_ctrl_t                   q_ctrl;
  csfw_pkg::q_flags_t                  q_flags;
  logic [THREAD_ID_BITS-1:0]           q_rd_id;
  logic                                cnt_neg;
  logic                                cnt_le_zero;

  csfw_queue #(
    .DEPTH   (QUEUE_DEPTH),
    .ID_BITS (THREAD_ID_BITS)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (q_ctrl),
    .push_id (tid_r),
    .flags   (q_flags),
    .rd_id   (q_rd_id)
  );

  assign tid_ext     = {THREAD_ID_BITS'(0), in_req.thread_id};
  assign rel_ext     = {csfw_pkg::THREAD_ID_W'(0), q_rd_id};
  assign cnt_neg     = count_r[csfw_pkg::COUNT_W-1];
  assign cnt_le_zero = cnt_neg || (count_r == '0);
  assign out_free    = !out_valid_r || out_rsp.ready;
  assign in_req.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    closed_nxt = closed_r;
    q_ctrl     = '0;
    out_load   = 1'b0;
    ld_status  = csfw_pkg::ST_GRANTED;
    ld_rel     = '0;
    ld_last    = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_type_r == csfw_pkg::REQ_NONE) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          state_nxt = S_IDLE;
          out_load  = 1'b1;
          if (closed_r) begin
            ld_status = csfw_pkg::ST_CLOSED_ERR;
          end else begin
            case (req_type_r)
              csfw_pkg::REQ_WAIT: begin
                if (cnt_le_zero) begin
                  if (q_flags.full) begin
                    ld_status = csfw_pkg::ST_QUEUE_FULL;
                  end else begin
                    q_ctrl.push = 1'b1;
                    count_nxt   = count_r - 1'b1;
                    ld_status   = csfw_pkg::ST_BLOCKED;
                  end
                end else begin
                  count_nxt = count_r - 1'b1;
                  ld_status = csfw_pkg::ST_GRANTED;
                end
              end
              csfw_pkg::REQ_SIGNAL: begin
                if (count_r == csfw_pkg::COUNT_MAX) begin
                  ld_status = csfw_pkg::ST_SATURATED;
                end else begin
                  count_nxt = count_r + 1'b1;
                  if (cnt_neg && !q_flags.empty) begin
                    q_ctrl.pop = 1'b1;
                    ld_status  = csfw_pkg::ST_REL_SIGNAL;
                    ld_rel     = rel_ext[csfw_pkg::REL_ID_W-1:0];
                  end else begin
                    ld_status = csfw_pkg::ST_NO_WAITER;
                  end
                end
              end
              csfw_pkg::REQ_CLOSE: begin
                if (q_flags.empty) begin
                  ld_status  = csfw_pkg::ST_CLOSED_EMPTY;
                  closed_nxt = 1'b1;
                end else begin
                  out_load  = 1'b0;
                  state_nxt = S_DRAIN;
                end
              end
              default: begin
                out_load = 1'b0;
              end
            endcase
          end
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          q_ctrl.pop = 1'b1;
          out_load   = 1'b1;
          ld_status  = csfw_pkg::ST_REL_CLOSE;
          ld_rel     = rel_ext[csfw_pkg::REL_ID_W-1:0];
          ld_last    = q_flags.one;
          if (q_flags.one) begin
            closed_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_we) begin
      count_nxt = {{(csfw_pkg::COUNT_W - csfw_pkg::CFG_W){1'b0}}, cfg_wdata};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      closed_r <= closed_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_type_r <= in_req.req_type;
      tid_r      <= tid_ext[THREAD_ID_BITS-1:0];
    end
    if (out_load) begin
      out_status_r <= ld_status;
      out_rel_r    <= ld_rel;
      out_last_r   <= ld_last;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.released_thread = out_rel_r;
  assign out_rsp.last            = out_last_r;

endmodule

### src/csfw_checker.sv
// port-level checks of the semaphore and their binding to the top level
module csfw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [csfw_pkg::STATUS_W-1:0] out_status,
  input logic [csfw_pkg::REL_ID_W-1:0] out_released,
  input logic                          out_last
);

  // pending result holds until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_released)
      && $stable(out_last))
    else $error("result changed while stalled");

  // a request is worked on before the next is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken during update cycle");

  // a close drain keeps the request side shut and streams without gaps
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken during close drain");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside close drain");

endmodule

bind counting_semaphore_fifo_waiters csfw_checker u_csfw_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .out_status   (out_rsp.status),
  .out_released (out_rsp.released_thread),
  .out_last     (out_rsp.last)
);

### dv/tb_counting_semaphore_fifo_waiters.sv
`timescale 1ns / 100ps
// testbench for the counting semaphore with a fifo of waiting thread ids
module tb_counting_semaphore_fifo_waiters;
  import csfw_pkg::*;

  localparam int DEPTH          = QUEUE_DEPTH_DEF;
  localparam logic [THREAD_ID_W-1:0] ID_MASK = THREAD_ID_W'((1 << THREAD_ID_BITS_DEF) - 1);
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_START     = 4;
  localparam int HOLD_LEN       = 150;
  localparam int STALL_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 20;
  localparam int RANDOM_REQUESTS = 70;

  typedef enum logic [2:0] {ACT_REQ, ACT_CFG, ACT_DRAIN, ACT_IDLE_ON, ACT_IDLE_OFF} act_kind_t;

  typedef struct packed {
    act_kind_t              kind;
    logic [REQ_TYPE_W-1:0]  rtype;
    logic [THREAD_ID_W-1:0] tid;
    logic [CFG_W-1:0]       value;
  } plan_entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [REL_ID_W-1:0] rel_id;
    logic                last;
  } sem_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  csfw_req_if req_ch();
  csfw_rsp_if rsp_ch();

  counting_semaphore_fifo_waiters dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  plan_entry_t             request_plan[$];
  sem_result_t             pending_results[$];
  logic [REL_ID_W-1:0]     waiters[$];
  int                      sem_count;
  bit                      sem_closed;
  int                      mismatches;
  bit                      idle_en;
  int                      gap_left;
  int                      settle_cnt;
  int                      stall_left;
  int                      ready_cycles;
  int                      quiet_cycles;
  int                      p_count;
  int                      p_occ;
  logic                    nxt_valid;
  logic                    nxt_we;
  logic                    nxt_ready;
  bit                      quiet;

  function automatic void push_result(logic [STATUS_W-1:0] st, logic [REL_ID_W-1:0] id,
                                      logic lst);
    sem_result_t r;
    r.status = st;
    r.rel_id = id;
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void semaphore_step(logic [REQ_TYPE_W-1:0] rtype,
                                         logic [THREAD_ID_W-1:0] tid);
    logic [REL_ID_W-1:0] id;
    id = tid & ID_MASK;
    if (rtype == REQ_NONE) return;
    if (sem_closed) begin
      push_result(ST_CLOSED_ERR, '0, 1'b1);
      return;
    end
    case (rtype)
      REQ_WAIT: begin
        if (sem_count - 1 < 0) begin
          if (waiters.size() >= DEPTH) begin
            push_result(ST_QUEUE_FULL, '0, 1'b1);
          end else begin
            sem_count--;
            waiters.push_back(id);
            push_result(ST_BLOCKED, '0, 1'b1);
          end
        end else begin
          sem_count--;
          push_result(ST_GRANTED, '0, 1'b1);
        end
      end
      REQ_SIGNAL: begin
        if (sem_count >= int'(COUNT_MAX)) begin
          push_result(ST_SATURATED, '0, 1'b1);
        end else begin
          sem_count++;
          if (sem_count <= 0 && waiters.size() > 0) begin
            id = waiters.pop_front();
            push_result(ST_REL_SIGNAL, id, 1'b1);
          end else begin
            push_result(ST_NO_WAITER, '0, 1'b1);
          end
        end
      end
      default: begin
        if (waiters.size() == 0) begin
          push_result(ST_CLOSED_EMPTY, '0, 1'b1);
        end else begin
          while (waiters.size() > 0) begin
            id = waiters.pop_front();
            push_result(ST_REL_CLOSE, id, waiters.size() == 0);
          end
        end
        sem_closed = 1'b1;
      end
    endcase
  endfunction

  // rough count and occupancy kept while building the plan, before the close
  task automatic add_req(logic [REQ_TYPE_W-1:0] rtype, logic [THREAD_ID_W-1:0] tid);
    plan_entry_t e;
    e = '{kind: ACT_REQ, rtype: rtype, tid: tid, value: '0};
    request_plan.push_back(e);
    if (rtype == REQ_WAIT) begin
      if (p_count - 1 >= 0) begin
        p_count--;
      end else if (p_occ < DEPTH) begin
        p_count--;
        p_occ++;
      end
    end else if (rtype == REQ_SIGNAL && p_count < int'(COUNT_MAX)) begin
      p_count++;
      if (p_count <= 0 && p_occ > 0) p_occ--;
    end
  endtask

  task automatic add_cfg(logic [CFG_W-1:0] value);
    plan_entry_t e;
    e = '{kind: ACT_CFG, rtype: REQ_NONE, tid: '0, value: value};
    request_plan.push_back(e);
    p_count = int'(value);
  endtask

  task automatic add_ctl(act_kind_t kind);
    plan_entry_t e;
    e = '{kind: kind, rtype: REQ_NONE, tid: '0, value: '0};
    request_plan.push_back(e);
  endtask

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      cfg_we       <= 1'b0;
      gap_left     = 0;
      settle_cnt   = 0;
    end else begin
      nxt_valid = req_ch.valid;
      nxt_we    = 1'b0;
      if (req_ch.valid && req_ch.ready) begin
        semaphore_step(req_ch.req_type, req_ch.thread_id);
        nxt_valid = 1'b0;
        if (idle_en && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 19);
      end
      quiet = pending_results.size() == 0 && !(rsp_ch.valid && rsp_ch.ready);
      if (!nxt_valid && request_plan.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (request_plan[0].kind)
            ACT_REQ: begin
              req_ch.req_type  <= request_plan[0].rtype;
              req_ch.thread_id <= request_plan[0].tid;
              nxt_valid = 1'b1;
              request_plan.delete(0);
            end
            ACT_DRAIN: begin
              if (quiet) request_plan.delete(0);
            end
            ACT_CFG: begin
              settle_cnt = quiet ? settle_cnt + 1 : 0;
              if (settle_cnt > SETTLE_CYCLES) begin
                cfg_wdata <= request_plan[0].value;
                nxt_we = 1'b1;
                sem_count = int'(request_plan[0].value);
                settle_cnt = 0;
                request_plan.delete(0);
              end
            end
            default: begin
              idle_en <= request_plan[0].kind == ACT_IDLE_ON;
              request_plan.delete(0);
            end
          endcase
        end
      end
      req_ch.valid <= nxt_valid;
      cfg_we       <= nxt_we;
    end
  end

  // result ready, with one long hold early on
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b1;
      stall_left   = 0;
      ready_cycles = 0;
    end else begin
      ready_cycles++;
      nxt_ready = 1'b1;
      if (ready_cycles >= HOLD_START && ready_cycles < HOLD_START + HOLD_LEN) begin
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        nxt_ready = 1'b0;
      end
      rsp_ch.ready <= nxt_ready;
    end
  end

  // result monitor
  always @(posedge clk) begin
    sem_result_t exp_r;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing expected: status %0d id %02h last %0d",
                             rsp_ch.status, rsp_ch.released_thread, rsp_ch.last));
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp_ch.status !== exp_r.status || rsp_ch.released_thread !== exp_r.rel_id ||
            rsp_ch.last !== exp_r.last) begin
          flag_error($sformatf("exp status %0d id %02h last %0d, got status %0d id %02h last %0d",
                               exp_r.status, exp_r.rel_id, exp_r.last, rsp_ch.status,
                               rsp_ch.released_thread, rsp_ch.last));
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** counting_semaphore_fifo_waiters: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int rand_items;
    int burst;
    int wait_pct;
    int sel;
    int fill;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_NONE;
    req_ch.thread_id = '0;
    rsp_ch.ready     = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    rst_n            = 1'b0;
    idle_en          = 1'b1;
    sem_count        = 0;
    sem_closed       = 1'b0;
    mismatches       = 0;
    p_count          = 0;
    p_occ            = 0;

    // directed: block, release in order, no waiter, grant, ignored request type
    add_cfg(16'h0000);
    add_req(REQ_WAIT, 8'h00);
    add_req(REQ_WAIT, 8'hFF);
    add_req(REQ_SIGNAL, 8'h3C);
    add_req(REQ_SIGNAL, 8'hC3);
    add_req(REQ_SIGNAL, 8'h00);
    add_req(REQ_WAIT, 8'h5A);
    add_req(REQ_NONE, 8'hA5);
    add_req(REQ_NONE, 8'h5A);

    // count loaded with the largest configuration value, still below the top of the register range
    add_ctl(ACT_IDLE_OFF);
    add_cfg(16'hFFFF);
    repeat (4) add_req(REQ_SIGNAL, 8'($urandom));
    add_req(REQ_WAIT, 8'hFF);
    add_ctl(ACT_IDLE_ON);

    // fill the waiter queue, then one wait too many
    add_cfg(16'h0000);
    for (int i = 0; i <= DEPTH; i++) add_req(REQ_WAIT, 8'(i * 17));

    rand_items = 0;
    while (rand_items < RANDOM_REQUESTS) begin
      if (p_occ == 0 && $urandom_range(0, 3) == 0) begin
        sel = $urandom_range(0, 5);
        add_cfg(sel == 0 ? 16'hFFFF : sel == 1 ? 16'($urandom) : 16'($urandom_range(0, 3)));
      end else if ($urandom_range(0, 4) == 0) begin
        add_ctl(ACT_DRAIN);
      end
      wait_pct = $urandom_range(1, 3) * 25;
      burst = $urandom_range(6, 16);
      repeat (burst) begin
        if ($urandom_range(0, 19) == 0) begin
          add_req(REQ_NONE, 8'($urandom));
        end else begin
          add_req(($urandom_range(0, 99) < wait_pct) ? REQ_WAIT : REQ_SIGNAL, 8'($urandom));
          rand_items++;
        end
      end
    end

    // final part: queue up to DEPTH waiters, reload the count under them, close, then request again
    add_ctl(ACT_IDLE_OFF);
    while (p_occ > 0) add_req(REQ_SIGNAL, 8'($urandom));
    add_cfg(16'h0000);
    sel = $urandom_range(0, 3);
    fill = sel == 0 ? 0 : sel == 1 ? $urandom_range(1, DEPTH - 1) : DEPTH;
    repeat (fill) add_req(REQ_WAIT, 8'($urandom));
    add_cfg(16'($urandom));
    add_req(REQ_CLOSE, 8'($urandom));
    for (int i = 0; i < 8; i++) add_req(REQ_TYPE_W'(i % 4), 8'($urandom));
    add_cfg(16'h0001);
    add_req(REQ_SIGNAL, 8'($urandom));
    add_req(REQ_WAIT, 8'($urandom));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (request_plan.size() != 0 || req_ch.valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("** counting_semaphore_fifo_waiters: PASSED **");
    end else begin
      $display("** counting_semaphore_fifo_waiters: FAILED **");
    end
    $finish;
  end

endmodule
